FILE: rtl/lpfr_pkg.sv
// shared types and constants for the length-prefixed frame receiver
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam int BYTE_W          = 8;

  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_TAKE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              write_enable;
    logic [BYTE_W-1:0] write_address;
    logic [BYTE_W-1:0] write_data;
    logic              packet_done;
    logic              ready_flag;
    logic              overflow_flag;
    logic [BYTE_W-1:0] fill_level;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lpfr_in_stage.sv
// input register of the frame receiver
// depends on lpfr_pkg for the item type
`timescale 1ns / 1ps
`default_nettype none

module lpfr_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [lpfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                       advance,
  output logic                            item_valid,
  output lpfr_pkg::item_t                 item
);
  import lpfr_pkg::*;

  // held item blocks a new one only when it cannot move on
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.cmd     <= cmd_t'(command);
      item.rx_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lpfr_core.sv
// framing state and per-item next-state logic of the frame receiver
// depends on lpfr_pkg for the item and result types
`timescale 1ns / 1ps
`default_nettype none

module lpfr_core #(
  parameter int STORE_DEPTH = lpfr_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire lpfr_pkg::item_t             item,
  input  wire logic [lpfr_pkg::BYTE_W-1:0] start_byte,
  output lpfr_pkg::result_t                res
);
  import lpfr_pkg::*;

  localparam int             PTR_W   = $clog2(STORE_DEPTH);
  localparam logic [PTR_W:0] DEPTH_V = (PTR_W+1)'(STORE_DEPTH);

  logic              begin_seen, begin_seen_next;
  logic              length_seen, length_seen_next;
  logic [BYTE_W-1:0] declared_length, declared_length_next;
  logic [BYTE_W-1:0] payload_count, payload_count_next;
  logic [PTR_W-1:0]  write_pointer, write_pointer_next;
  logic [PTR_W-1:0]  fill_count, fill_count_next;
  logic              ready, ready_next;
  logic              overflowed, overflowed_next;

  logic              we;
  logic [BYTE_W-1:0] data;
  logic              done;
  logic [PTR_W:0]    ptr_inc;
  logic [PTR_W:0]    fill_inc;
  logic [BYTE_W-1:0] ptr_low;
  logic [BYTE_W-1:0] fill_low;

  assign ptr_inc  = {1'b0, write_pointer} + (PTR_W+1)'(1);
  assign fill_inc = {1'b0, fill_count} + (PTR_W+1)'(1);

  always_comb begin
    begin_seen_next      = begin_seen;
    length_seen_next     = length_seen;
    declared_length_next = declared_length;
    payload_count_next   = payload_count;
    write_pointer_next   = write_pointer;
    fill_count_next      = fill_count;
    ready_next           = ready;
    overflowed_next      = overflowed;
    we                   = 1'b0;
    data                 = '0;
    done                 = 1'b0;
    unique case (item.cmd)
      CMD_RX: begin
        if (length_seen) begin
          if (payload_count < declared_length) begin
            payload_count_next = payload_count + BYTE_W'(1);
            we                 = 1'b1;
            data               = item.rx_byte;
          end else begin
            // trailing byte closes the packet
            payload_count_next = '0;
            length_seen_next   = 1'b0;
            begin_seen_next    = 1'b0;
            ready_next         = 1'b1;
            done               = 1'b1;
          end
        end else if (begin_seen) begin
          length_seen_next     = 1'b1;
          declared_length_next = item.rx_byte;
          we                   = 1'b1;
          data                 = item.rx_byte;
        end
        // start byte opens a packet, also right after one closes
        if (!we && !begin_seen_next && (item.rx_byte == start_byte)) begin
          begin_seen_next = 1'b1;
          we              = 1'b1;
          data            = item.rx_byte;
        end
        if (we) begin
          write_pointer_next = (ptr_inc == DEPTH_V) ? '0 : ptr_inc[PTR_W-1:0];
          if (fill_inc == DEPTH_V) begin
            fill_count_next = '0;
            overflowed_next = 1'b1;
          end else begin
            fill_count_next = fill_inc[PTR_W-1:0];
          end
        end
      end
      CMD_TAKE: begin
        if (fill_count != '0) begin
          fill_count_next = fill_count - PTR_W'(1);
        end
      end
      CMD_CLEAR: begin
        ready_next      = 1'b0;
        overflowed_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_seen      <= 1'b0;
      length_seen     <= 1'b0;
      declared_length <= '0;
      payload_count   <= '0;
      write_pointer   <= '0;
      fill_count      <= '0;
      ready           <= 1'b0;
      overflowed      <= 1'b0;
    end else if (fire) begin
      begin_seen      <= begin_seen_next;
      length_seen     <= length_seen_next;
      declared_length <= declared_length_next;
      payload_count   <= payload_count_next;
      write_pointer   <= write_pointer_next;
      fill_count      <= fill_count_next;
      ready           <= ready_next;
      overflowed      <= overflowed_next;
    end
  end

  // low byte of pointer and count for reporting
  generate
    if (PTR_W >= BYTE_W) begin : g_wide
      assign ptr_low  = write_pointer[BYTE_W-1:0];
      assign fill_low = fill_count_next[BYTE_W-1:0];
    end else begin : g_narrow
      assign ptr_low  = {{(BYTE_W-PTR_W){1'b0}}, write_pointer};
      assign fill_low = {{(BYTE_W-PTR_W){1'b0}}, fill_count_next};
    end
  endgenerate

  always_comb begin
    res.write_enable  = we;
    res.write_address = we ? ptr_low : '0;
    res.write_data    = data;
    res.packet_done   = done;
    res.ready_flag    = ready_next;
    res.overflow_flag = overflowed_next;
    res.fill_level    = fill_low;
  end

endmodule

`default_nettype wire

FILE: rtl/lpfr_out_stage.sv
// result register of the frame receiver
// depends on lpfr_pkg for the result type
`timescale 1ns / 1ps
`default_nettype none

module lpfr_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire lpfr_pkg::result_t res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lpfr_pkg::result_t      out_res
);
  import lpfr_pkg::*;

  // register is free when empty or being drained this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_frame_receiver.sv
// top level of the length-prefixed frame receiver
// depends on lpfr_pkg, lpfr_in_stage, lpfr_core and lpfr_out_stage
`timescale 1ns / 1ps
`default_nettype none

// Frames packets out of a byte stream: a packet is the start byte (cfg
// register), a length byte N and N payload bytes. Each of these bytes yields
// a store write report (address into a STORE_DEPTH ring, byte); the byte
// after the payload pulses packet_done and sets the sticky ready flag; it
// is stored only if it equals the start byte, which opens the next packet. The
// fill count wraps to zero and sets the sticky overflow flag on reaching the
// depth; command 1 lowers it (saturating at zero), command 2 clears both
// flags. Every item gives exactly one result item. Throughput is one item per
// clock while the consumer does not stall; an item passes through the input
// register, the combinational framing update and the result register. Write
// start_byte only while no item is in flight. For depths above 256 the
// address and fill level report the low eight bits.

module length_prefixed_frame_receiver #(
  parameter int STORE_DEPTH = lpfr_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration: start byte
  input  wire logic                        cfg_write,
  input  wire logic [lpfr_pkg::BYTE_W-1:0] cfg_data,
  // input items
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  command,
  input  wire logic [lpfr_pkg::BYTE_W-1:0] rx_byte,
  // result items
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             write_enable,
  output logic [lpfr_pkg::BYTE_W-1:0]      write_address,
  output logic [lpfr_pkg::BYTE_W-1:0]      write_data,
  output logic                             packet_done,
  output logic                             ready_flag,
  output logic                             overflow_flag,
  output logic [lpfr_pkg::BYTE_W-1:0]      fill_level
);
  import lpfr_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  logic              advance;
  logic              item_valid;
  item_t             item;
  logic              fire;
  result_t           res;
  result_t           out_res;

  // start byte register; the user writes it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
    end else if (cfg_write) begin
      start_byte <= cfg_data;
    end
  end

  // input register: holds the item while the result side is blocked
  lpfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // held item is processed in the cycle it moves into the result register
  assign fire = item_valid && advance;

  // framing state machine and store pointer / fill bookkeeping
  lpfr_core #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (item),
    .start_byte (start_byte),
    .res        (res)
  );

  // result register, decouples the consumer stall from new input items
  lpfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign write_enable  = out_res.write_enable;
  assign write_address = out_res.write_address;
  assign write_data    = out_res.write_data;
  assign packet_done   = out_res.packet_done;
  assign ready_flag    = out_res.ready_flag;
  assign overflow_flag = out_res.overflow_flag;
  assign fill_level    = out_res.fill_level;

`ifndef SYNTH
  // input only backs up when the result register is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register could take an item");

  // a finished packet always leaves the ready flag set
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_done) |-> ready_flag)
    else $error("packet_done without ready flag");

  // a write on the closing byte can only be the next start byte
  a_done_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_done && write_enable) |-> (write_data == start_byte))
    else $error("closing byte stored but it is not the start byte");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_length_prefixed_frame_receiver.sv
// self-checking testbench for length_prefixed_frame_receiver
// depends on lpfr_pkg and the rtl of the block; predicts every result item and checks it in order
`timescale 1ns / 1ps

module tb_length_prefixed_frame_receiver;
  import lpfr_pkg::*;

  // pipeline depth of the block, two register stages
  localparam int LATENCY     = 2;
  localparam int DEPTH       = STORE_DEPTH_DEF;
  // slowest legal run stays far below this
  localparam int CYCLE_LIMIT = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [BYTE_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cmd_t                command_in = CMD_RX;
  logic [BYTE_W-1:0]   rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                write_enable;
  logic [BYTE_W-1:0]   write_address;
  logic [BYTE_W-1:0]   write_data;
  logic                packet_done;
  logic                ready_flag;
  logic                overflow_flag;
  logic [BYTE_W-1:0]   fill_level;

  // shadow of the framing state, updated as each item is accepted
  logic [BYTE_W-1:0]   start_val = '0;
  bit                  opened = 1'b0;
  bit                  len_taken = 1'b0;
  logic [BYTE_W-1:0]   frame_len = '0;
  logic [BYTE_W-1:0]   body_count = '0;
  int                  wr_ptr = 0;
  int                  fill_cnt = 0;
  bit                  rdy = 1'b0;
  bit                  ovf = 1'b0;

  result_t             pending_reports[$];
  int                  items_taken = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;
  // both sides stop idling while set
  bit                  no_idle = 1'b0;
  // receiver hold-off request, in cycles
  int                  long_hold = 0;

  length_prefixed_frame_receiver i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command_in),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_enable  (write_enable),
    .write_address (write_address),
    .write_data    (write_data),
    .packet_done   (packet_done),
    .ready_flag    (ready_flag),
    .overflow_flag (overflow_flag),
    .fill_level    (fill_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // idle length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // one store write: report the slot, advance the ring pointer, bump the fill count
  function automatic void ring_write(input logic [BYTE_W-1:0] b, inout result_t r);
    r.write_enable  = 1'b1;
    r.write_address = wr_ptr[BYTE_W-1:0];
    r.write_data    = b;
    wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    fill_cnt = fill_cnt + 1;
    // reaching the depth wraps the count and latches overflow
    if (fill_cnt >= DEPTH) begin
      fill_cnt = 0;
      ovf = 1'b1;
    end
  endfunction

  // framing prediction for one accepted item
  function automatic result_t frame_predict(input cmd_t c, input logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    case (c)
      CMD_RX: begin
        if (len_taken) begin
          if (body_count < frame_len) begin
            body_count = body_count + 1'b1;
            ring_write(b, r);
          end else begin
            // byte after the payload closes the packet; stored only if it reopens below
            body_count = '0;
            len_taken = 1'b0;
            opened = 1'b0;
            rdy = 1'b1;
            r.packet_done = 1'b1;
          end
        end else if (opened) begin
          // length byte, stored as well
          len_taken = 1'b1;
          frame_len = b;
          ring_write(b, r);
        end
        // an idle start byte opens a packet, also the one that just closed a packet
        if (!r.write_enable && !opened && b == start_val) begin
          opened = 1'b1;
          ring_write(b, r);
        end
      end
      CMD_TAKE: begin
        // saturates at an empty store
        if (fill_cnt > 0) fill_cnt = fill_cnt - 1;
      end
      CMD_CLEAR: begin
        rdy = 1'b0;
        ovf = 1'b0;
      end
      default: begin
      end
    endcase
    r.ready_flag    = rdy;
    r.overflow_flag = ovf;
    r.fill_level    = fill_cnt[BYTE_W-1:0];
    return r;
  endfunction

  // offer one item after a random gap, hold it until accepted
  task automatic send_item(input cmd_t c, input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command_in <= c;
    rx_byte    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(frame_predict(c, b));
    items_taken++;
  endtask

  // sender goes quiet until every predicted item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // start byte may only change with nothing in flight
  task automatic set_start_byte(input logic [BYTE_W-1:0] v);
    wait_drained();
    repeat (LATENCY + 2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    start_val = v;
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result item with no prediction pending");
        mismatches++;
      end else begin
        e = pending_reports.pop_front();
        if (write_enable !== e.write_enable) begin
          $error("write_enable expected %0d got %0d", e.write_enable, write_enable);
          mismatches++;
        end
        if (write_address !== e.write_address) begin
          $error("write_address expected %0h got %0h", e.write_address, write_address);
          mismatches++;
        end
        if (write_data !== e.write_data) begin
          $error("write_data expected %0h got %0h", e.write_data, write_data);
          mismatches++;
        end
        if (packet_done !== e.packet_done) begin
          $error("packet_done expected %0d got %0d", e.packet_done, packet_done);
          mismatches++;
        end
        if (ready_flag !== e.ready_flag) begin
          $error("ready_flag expected %0d got %0d", e.ready_flag, ready_flag);
          mismatches++;
        end
        if (overflow_flag !== e.overflow_flag) begin
          $error("overflow_flag expected %0d got %0d", e.overflow_flag, overflow_flag);
          mismatches++;
        end
        if (fill_level !== e.fill_level) begin
          $error("fill_level expected %0d got %0d", e.fill_level, fill_level);
          mismatches++;
        end
      end
    end
  end

  // reset value of the start byte is zero; also a take on an empty store
  task automatic test_reset_start_byte();
    send_item(CMD_TAKE, 8'h00);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_RX, 8'h7E);
    send_item(CMD_TAKE, 8'hFF);
    send_item(CMD_CLEAR, 8'h00);
  endtask

  // zero-length packet, start byte inside a payload, start byte as terminator,
  // commands that carry a start byte but must not open a packet
  task automatic test_frame_shapes();
    set_start_byte(8'hA5);
    send_item(CMD_RX, 8'h3C);
    send_item(CMD_NONE, 8'hA5);
    send_item(CMD_TAKE, 8'hA5);
    send_item(CMD_RX, 8'hA5);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_RX, 8'h11);
    send_item(CMD_RX, 8'hA5);
    send_item(CMD_RX, 8'h03);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_RX, 8'hA5);
    send_item(CMD_RX, 8'hFF);
    send_item(CMD_RX, 8'hA5);
    send_item(CMD_RX, 8'h01);
    send_item(CMD_RX, 8'h5A);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_CLEAR, 8'hFF);
    send_item(CMD_TAKE, 8'h00);
  endtask

  // longest packet, back to back: the fill count passes the depth and wraps
  task automatic test_ring_overflow();
    int k;
    set_start_byte(8'hFF);
    no_idle = 1'b1;
    send_item(CMD_RX, 8'hFF);
    send_item(CMD_RX, 8'hFF);
    for (k = 0; k < 255; k++) send_item(CMD_RX, 8'($urandom_range(0, 255)));
    send_item(CMD_RX, 8'hFF);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_CLEAR, 8'h00);
    wait_drained();
    no_idle = 1'b0;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    int k;
    no_idle = 1'b1;
    long_hold = 120;
    send_item(CMD_RX, start_val);
    send_item(CMD_RX, 8'd20);
    for (k = 0; k < 28; k++) send_item(CMD_RX, 8'($urandom_range(0, 255)));
    wait_drained();
    no_idle = 1'b0;
  endtask

  // mostly well-formed packets with random content, the rest noise and
  // truncated packets; consumer commands sprinkled in
  task automatic test_random_traffic(input logic [BYTE_W-1:0] sb, input int n_items);
    int stop_at;
    int len;
    int k;
    bit reopened;
    logic [BYTE_W-1:0] b;
    set_start_byte(sb);
    stop_at = items_taken + n_items;
    reopened = 1'b0;
    while (items_taken < stop_at) begin
      if ($urandom_range(0, 99) < 75) begin
        if (!reopened) send_item(CMD_RX, start_val);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        send_item(CMD_RX, 8'(len));
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(cmd_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
          send_item(CMD_RX, 8'($urandom_range(0, 255)));
        end
        reopened = 1'($urandom_range(0, 1));
        b = 8'($urandom_range(0, 255));
        if (reopened) b = start_val;
        else if (b == start_val) b = b + 1'b1;
        send_item(CMD_RX, b);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // raw noise, any command
            for (k = $urandom_range(1, 6); k > 0; k--)
              send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end
          1: begin
            // packet cut short, the following bytes land wherever the framing is
            send_item(CMD_RX, start_val);
            send_item(CMD_RX, 8'($urandom_range(2, 12)));
            send_item(CMD_RX, 8'($urandom_range(0, 255)));
          end
          default: begin
            // consumer drains a few bytes
            for (k = $urandom_range(1, 10); k > 0; k--)
              send_item(CMD_TAKE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
          end
        endcase
        reopened = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_start_byte();
    test_frame_shapes();
    test_ring_overflow();
    test_output_backpressure();
    test_random_traffic(8'h00, 180);
    test_random_traffic(8'($urandom_range(1, 254)), 180);
    test_random_traffic(8'hFF, 180);
    wait_drained();
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
